[design/dpb_pkg.sv]
// shared types and constants for the depth-to-point back-projection block
// no dependencies
`default_nettype none

package dpb_pkg;

  localparam int POS_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int INDEX_W = 24;
  localparam int DIM_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_SCALE = 3'd6;

  // camera intrinsics used by the arithmetic back end
  typedef struct packed {
    logic [15:0] principal_x;
    logic [15:0] principal_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [31:0] inv_depth_scale;
  } cam_cfg_t;

  // classified pixel, front to back
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic [INDEX_W-1:0] index;
    logic               frame_end;
  } pix_t;

  // finished point
  typedef struct packed {
    logic [31:0]        point_x;
    logic [31:0]        point_y;
    logic [31:0]        point_z;
    logic               point_valid;
    logic [INDEX_W-1:0] pixel_index;
    logic               frame_end;
  } result_t;

endpackage

`default_nettype wire

[design/dpb_fifo.sv]
// small first-word-fall-through queue built on a register array
// no dependencies
`default_nettype none

module dpb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  output logic      [WIDTH-1:0]         rd_data,
  output logic                          full,
  output logic                          empty,
  output logic      [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_ok) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (wr_ok && !rd_ok) begin
        count <= count + (AW+1)'(1);
      end else if (rd_ok && !wr_ok) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/dpb_front.sv]
// front end: takes depth words, tracks column/row/flat position, classifies
// depends on dpb_pkg
`default_nettype none

module dpb_front #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [dpb_pkg::DEPTH_W-1:0] depth_raw,
  input  wire logic [dpb_pkg::DIM_W-1:0]   frame_width,
  input  wire logic [dpb_pkg::DIM_W-1:0]   frame_height,
  output logic                             q_wr,
  output dpb_pkg::pix_t                    q_word,
  input  wire logic                        q_full
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam logic [dpb_pkg::DIM_W-1:0] DIM_LIM = dpb_pkg::DIM_W'(MAX_DIM);

  logic [CNT_W-1:0]            column_count;
  logic [CNT_W-1:0]            row_count;
  logic [dpb_pkg::INDEX_W-1:0] flat_count;
  logic [dpb_pkg::DIM_W-1:0]   w_eff;
  logic [dpb_pkg::DIM_W-1:0]   h_eff;
  logic                        last_col;
  logic                        last_row;
  logic                        frame_end;
  logic                        accept;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = dpb_pkg::DIM_W'(1);
    end else if (frame_width > DIM_LIM) begin
      w_eff = DIM_LIM;
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = dpb_pkg::DIM_W'(1);
    end else if (frame_height > DIM_LIM) begin
      h_eff = DIM_LIM;
    end else begin
      h_eff = frame_height;
    end
  end

  // a counter past its bound counts as on the last position
  assign last_col  = dpb_pkg::DIM_W'(column_count) >= (w_eff - dpb_pkg::DIM_W'(1));
  assign last_row  = dpb_pkg::DIM_W'(row_count) >= (h_eff - dpb_pkg::DIM_W'(1));
  assign frame_end = last_col && last_row;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept;

  always_comb begin
    q_word.depth     = depth_raw;
    q_word.col       = dpb_pkg::POS_W'(column_count);
    q_word.row       = dpb_pkg::POS_W'(row_count);
    q_word.index     = flat_count;
    q_word.frame_end = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      flat_count   <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
      flat_count <= frame_end ? '0 : flat_count + dpb_pkg::INDEX_W'(1);
    end
  end

endmodule

`default_nettype wire

[design/dpb_back.sv]
// back end: three-stage fixed-point projection pipeline and result queue
// depends on dpb_pkg and dpb_fifo
`default_nettype none

module dpb_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dpb_pkg::cam_cfg_t cam,
  input  wire logic              q_empty,
  output logic                   q_rd,
  input  wire dpb_pkg::pix_t     q_word,
  input  wire logic              pop,
  output logic                   empty,
  output dpb_pkg::result_t       res
);

  localparam int OUT_DEPTH = 8;
  localparam int OCNT_W    = $clog2(OUT_DEPTH) + 1;

  typedef struct packed {
    logic                        nz;
    logic                        neg_x;
    logic                        neg_y;
    logic [dpb_pkg::INDEX_W-1:0] index;
    logic                        frame_end;
  } meta_t;

  // stage 1: depth product and offsets
  logic        s1_v;
  meta_t       s1_meta;
  logic [47:0] s1_prod;
  logic [15:0] s1_dx;
  logic [15:0] s1_dy;
  // stage 2: saturated z and offset times z
  logic        s2_v;
  meta_t       s2_meta;
  logic [30:0] s2_z;
  logic [46:0] s2_mx;
  logic [46:0] s2_my;
  // stage 3: partial products with the reciprocal halves
  logic        s3_v;
  meta_t       s3_meta;
  logic [30:0] s3_z;
  logic [58:0] s3_ax;
  logic [60:0] s3_bx;
  logic [58:0] s3_ay;
  logic [60:0] s3_by;

  logic [15:0]        p16x;
  logic [15:0]        p16y;
  logic               neg_x;
  logic               neg_y;
  logic [48:0]        z_round;
  logic [32:0]        z_full;
  logic [30:0]        z_sat;
  logic [1:0]         inflight;
  logic [OCNT_W-1:0]  out_count;
  logic               out_full;
  dpb_pkg::result_t   out_word;

  function automatic logic [31:0] finish(input logic [58:0] a, input logic [60:0] b,
                                         input logic neg);
    logic [59:0] sum;
    logic [43:0] mag;
    logic [31:0] lim;
    sum = {1'b0, a} + 60'(b[60:12]);
    mag = sum[59:16];
    if (!neg) begin
      lim = (mag > 44'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
      return lim;
    end
    lim = (mag > 44'h080000000) ? 32'h80000000 : mag[31:0];
    return 32'd0 - lim;
  endfunction

  // issue only when the result queue has room for everything in flight
  assign inflight = 2'(s1_v) + 2'(s2_v) + 2'(s3_v);
  assign q_rd = !q_empty &&
                ((OCNT_W+1)'(out_count) + (OCNT_W+1)'(inflight) < (OCNT_W+1)'(OUT_DEPTH));

  assign p16x  = {q_word.col, 4'b0000};
  assign p16y  = {q_word.row, 4'b0000};
  assign neg_x = p16x < cam.principal_x;
  assign neg_y = p16y < cam.principal_y;

  assign z_round = {1'b0, s1_prod} + 49'd32768;
  assign z_full  = z_round[48:16];
  assign z_sat   = (z_full > 33'h07FFFFFFF) ? 31'h7FFFFFFF : z_full[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= q_rd;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_meta.nz        <= (q_word.depth != '0);
    s1_meta.neg_x     <= neg_x;
    s1_meta.neg_y     <= neg_y;
    s1_meta.index     <= q_word.index;
    s1_meta.frame_end <= q_word.frame_end;
    s1_prod <= 48'(q_word.depth) * 48'(cam.inv_depth_scale);
    s1_dx   <= neg_x ? cam.principal_x - p16x : p16x - cam.principal_x;
    s1_dy   <= neg_y ? cam.principal_y - p16y : p16y - cam.principal_y;

    s2_meta <= s1_meta;
    s2_z    <= z_sat;
    s2_mx   <= 47'(s1_dx) * 47'(z_sat);
    s2_my   <= 47'(s1_dy) * 47'(z_sat);

    s3_meta <= s2_meta;
    s3_z    <= s2_z;
    s3_ax   <= 59'(s2_mx) * 59'(cam.inv_focal_x[23:12]);
    s3_bx   <= 61'(s2_mx) * 61'(cam.inv_focal_x[11:0]) + 61'd134217728;
    s3_ay   <= 59'(s2_my) * 59'(cam.inv_focal_y[23:12]);
    s3_by   <= 61'(s2_my) * 61'(cam.inv_focal_y[11:0]) + 61'd134217728;
  end

  always_comb begin
    out_word.point_valid = s3_meta.nz;
    out_word.pixel_index = s3_meta.index;
    out_word.frame_end   = s3_meta.frame_end;
    if (s3_meta.nz) begin
      out_word.point_x = finish(s3_ax, s3_bx, s3_meta.neg_x);
      out_word.point_y = finish(s3_ay, s3_by, s3_meta.neg_y);
      out_word.point_z = {1'b0, s3_z};
    end else begin
      out_word.point_x = '0;
      out_word.point_y = '0;
      out_word.point_z = '0;
    end
  end

  dpb_fifo #(
    .WIDTH ($bits(dpb_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s3_v),
    .wr_data (out_word),
    .rd_en   (pop),
    .rd_data (res),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  // out_full never blocks a write: issue is gated by the occupancy above
  logic unused_full;
  assign unused_full = out_full;

endmodule

`default_nettype wire

[design/depth_to_point_backprojection.sv]
// depth-to-point back-projection top level: config registers, front, queue, back
// throughput: one word per cycle until the result queue fills; single-issue back end
// reset: synchronous, clears counters and queues, loads register defaults
// depends on dpb_pkg, dpb_front, dpb_fifo, dpb_back
`default_nettype none

module depth_to_point_backprojection #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write channel, always ready
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // depth words in
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [dpb_pkg::DEPTH_W-1:0]     depth_raw,
  // points out
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [31:0]                          point_x,
  output logic [31:0]                          point_y,
  output logic [31:0]                          point_z,
  output logic                                 point_valid,
  output logic [dpb_pkg::INDEX_W-1:0]          pixel_index,
  output logic                                 frame_end
);

  localparam int MID_DEPTH = 4;

  // configuration registers
  logic [dpb_pkg::DIM_W-1:0] frame_width;
  logic [dpb_pkg::DIM_W-1:0] frame_height;
  dpb_pkg::cam_cfg_t         cam;

  // front-to-back queue
  logic             mid_wr;
  dpb_pkg::pix_t    mid_in;
  logic             mid_full;
  logic             mid_rd;
  dpb_pkg::pix_t    mid_out;
  logic             mid_empty;
  logic [$clog2(MID_DEPTH):0] mid_count;

  dpb_pkg::result_t res;

  assign cfg_ready = 1'b1;

  // register writes, each index keeps only its own low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width         <= 13'd640;
      frame_height        <= 13'd480;
      cam.principal_x     <= 16'd5120;
      cam.principal_y     <= 16'd3840;
      cam.inv_focal_x     <= 24'd32263;
      cam.inv_focal_y     <= 24'd32263;
      cam.inv_depth_scale <= 32'd858993;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpb_pkg::REG_FRAME_WIDTH:     frame_width         <= cfg_data[12:0];
        dpb_pkg::REG_FRAME_HEIGHT:    frame_height        <= cfg_data[12:0];
        dpb_pkg::REG_PRINCIPAL_X:     cam.principal_x     <= cfg_data[15:0];
        dpb_pkg::REG_PRINCIPAL_Y:     cam.principal_y     <= cfg_data[15:0];
        dpb_pkg::REG_INV_FOCAL_X:     cam.inv_focal_x     <= cfg_data[23:0];
        dpb_pkg::REG_INV_FOCAL_Y:     cam.inv_focal_y     <= cfg_data[23:0];
        dpb_pkg::REG_INV_DEPTH_SCALE: cam.inv_depth_scale <= cfg_data;
        default: begin
          // writes to unused indexes are dropped
        end
      endcase
    end
  end

  // front: position tracking and classification of each depth word
  dpb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .depth_raw    (depth_raw),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_wr         (mid_wr),
    .q_word       (mid_in),
    .q_full       (mid_full)
  );

  // short queue decoupling the front from the arithmetic
  dpb_fifo #(
    .WIDTH ($bits(dpb_pkg::pix_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_data (mid_in),
    .rd_en   (mid_rd),
    .rd_data (mid_out),
    .full    (mid_full),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  // back: z, x, y arithmetic and the result queue
  dpb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cam     (cam),
    .q_empty (mid_empty),
    .q_rd    (mid_rd),
    .q_word  (mid_out),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  // queue fill level is informational only
  logic unused_mid_count;
  assign unused_mid_count = ^mid_count;

  assign point_x     = res.point_x;
  assign point_y     = res.point_y;
  assign point_z     = res.point_z;
  assign point_valid = res.point_valid;
  assign pixel_index = res.pixel_index;
  assign frame_end   = res.frame_end;

endmodule

`default_nettype wire

[dv/dpb_point_checker.sv]
// point checker: mirrors the camera registers and pixel counters, predicts each point
// word and compares it with what the back-projection block pops; depends on dpb_pkg
`timescale 1ns / 1ps

module dpb_point_checker #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  input  logic                           full,
  input  logic [dpb_pkg::DEPTH_W-1:0]    depth_raw,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [31:0]                    point_x,
  input  logic [31:0]                    point_y,
  input  logic [31:0]                    point_z,
  input  logic                           point_valid,
  input  logic [dpb_pkg::INDEX_W-1:0]    pixel_index,
  input  logic                           frame_end,
  output int                             mismatches,
  output int                             outstanding,
  output int                             points_checked,
  output int                             valid_points,
  output int                             frames_closed
);

  localparam int REPORT_CAP = 40;

  // mirrored camera registers
  logic [dpb_pkg::DIM_W-1:0]   width_reg;
  logic [dpb_pkg::DIM_W-1:0]   height_reg;
  logic [15:0]                 center_x;
  logic [15:0]                 center_y;
  logic [23:0]                 recip_fx;
  logic [23:0]                 recip_fy;
  logic [31:0]                 depth_scale;

  // raster position of the next pixel
  logic [dpb_pkg::POS_W-1:0]   col_pos;
  logic [dpb_pkg::POS_W-1:0]   row_pos;
  logic [dpb_pkg::INDEX_W-1:0] flat_pos;

  dpb_pkg::result_t pending_points[$];
  dpb_pkg::result_t want;

  function automatic logic [dpb_pkg::DIM_W-1:0] clamp_dim(
      input logic [dpb_pkg::DIM_W-1:0] d);
    if (d == 0) return dpb_pkg::DIM_W'(1);
    if (d > MAX_DIM) return dpb_pkg::DIM_W'(MAX_DIM);
    return d;
  endfunction

  // (16*pos - center) * z * recip, rounded half away from zero to Q16.16, saturated
  function automatic logic [31:0] project_axis(input logic [dpb_pkg::POS_W-1:0] pos,
                                               input logic [15:0] center,
                                               input logic [63:0] z,
                                               input logic [23:0] recip);
    logic [63:0] p16, c, d, m, hi, lo, a, b, mag;
    logic        neg;
    p16 = 64'({pos, 4'b0000});
    c   = 64'(center);
    neg = p16 < c;
    d   = neg ? c - p16 : p16 - c;
    m   = d * z;
    hi  = 64'(recip[23:12]);
    lo  = 64'(recip[11:0]);
    a   = m * hi;
    b   = m * lo + 64'h800_0000;
    mag = (a + (b >> 12)) >> 16;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    return 32'd0 - mag[31:0];
  endfunction

  // predict the point for one depth word and step the raster counters
  function automatic dpb_pkg::result_t backproject(
      input logic [dpb_pkg::DEPTH_W-1:0] depth);
    dpb_pkg::result_t          pt;
    logic [dpb_pkg::DIM_W-1:0] w, h;
    logic                      last_col, last_row;
    logic [63:0]               d64, s64, z;
    w        = clamp_dim(width_reg);
    h        = clamp_dim(height_reg);
    last_col = {1'b0, col_pos} >= w - dpb_pkg::DIM_W'(1);
    last_row = {1'b0, row_pos} >= h - dpb_pkg::DIM_W'(1);
    pt       = '0;
    if (depth != 0) begin
      d64 = 64'(depth);
      s64 = 64'(depth_scale);
      z   = (d64 * s64 + 64'h8000) >> 16;
      if (z > 64'h7FFF_FFFF) z = 64'h7FFF_FFFF;
      pt.point_x     = project_axis(col_pos, center_x, z, recip_fx);
      pt.point_y     = project_axis(row_pos, center_y, z, recip_fy);
      pt.point_z     = z[31:0];
      pt.point_valid = 1'b1;
    end
    pt.pixel_index = flat_pos;
    pt.frame_end   = last_col && last_row;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + dpb_pkg::POS_W'(1);
    end else begin
      col_pos = col_pos + dpb_pkg::POS_W'(1);
    end
    flat_pos = pt.frame_end ? '0 : flat_pos + dpb_pkg::INDEX_W'(1);
    return pt;
  endfunction

  function automatic void compare_field(input string label, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
    if (want_v !== got_v) begin
      if (mismatches < REPORT_CAP)
        $display("%0t: %s mismatch at pixel %0d, expected 0x%08h, got 0x%08h",
                 $time, label, want.pixel_index, want_v, got_v);
      mismatches++;
      if (mismatches == REPORT_CAP) $display("%0t: further mismatches not shown", $time);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg   = 13'd640;
      height_reg  = 13'd480;
      center_x    = 16'd5120;
      center_y    = 16'd3840;
      recip_fx    = 24'd32263;
      recip_fy    = 24'd32263;
      depth_scale = 32'd858993;
      col_pos     = '0;
      row_pos     = '0;
      flat_pos    = '0;
      mismatches  = 0;
      pending_points.delete();
    end else begin
      // compare the popped word first, a fresh push can never be its match
      if (pop && !empty) begin
        if (pending_points.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $display("%0t: point word with nothing expected, expected none, got pixel %0d",
                     $time, pixel_index);
          mismatches++;
        end else begin
          want = pending_points.pop_front();
          compare_field("point_x", want.point_x, point_x);
          compare_field("point_y", want.point_y, point_y);
          compare_field("point_z", want.point_z, point_z);
          compare_field("point_valid", 32'(want.point_valid), 32'(point_valid));
          compare_field("pixel_index", 32'(want.pixel_index), 32'(pixel_index));
          compare_field("frame_end", 32'(want.frame_end), 32'(frame_end));
          points_checked++;
          if (want.point_valid) valid_points++;
          if (want.frame_end) frames_closed++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dpb_pkg::REG_FRAME_WIDTH:     width_reg   = cfg_data[12:0];
          dpb_pkg::REG_FRAME_HEIGHT:    height_reg  = cfg_data[12:0];
          dpb_pkg::REG_PRINCIPAL_X:     center_x    = cfg_data[15:0];
          dpb_pkg::REG_PRINCIPAL_Y:     center_y    = cfg_data[15:0];
          dpb_pkg::REG_INV_FOCAL_X:     recip_fx    = cfg_data[23:0];
          dpb_pkg::REG_INV_FOCAL_Y:     recip_fy    = cfg_data[23:0];
          dpb_pkg::REG_INV_DEPTH_SCALE: depth_scale = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) pending_points.push_back(backproject(depth_raw));
    end
    outstanding = pending_points.size();
  end

endmodule

[dv/tb_depth_to_point_backprojection.sv]
// testbench top for depth_to_point_backprojection: drives depth words and camera
// register writes, gives the verdict; depends on dpb_pkg, dpb_point_checker and the rtl
`timescale 1ns / 1ps

module tb_depth_to_point_backprojection;

  localparam int SETTLE_CYCLES = 12;    // extra margin after the last point word came back
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off to fill the queue
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up

  logic                           clk;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           push;
  logic                           full;
  logic [dpb_pkg::DEPTH_W-1:0]    depth_raw;
  logic                           empty;
  logic                           pop;
  logic [31:0]                    point_x;
  logic [31:0]                    point_y;
  logic [31:0]                    point_z;
  logic                           point_valid;
  logic [dpb_pkg::INDEX_W-1:0]    pixel_index;
  logic                           frame_end;

  int mismatches;
  int outstanding;
  int points_checked;
  int valid_points;
  int frames_closed;
  int settings_used;
  int stall_cycles;

  // coordination between the word source and the point sink
  bit hold_request;
  bit hold_done;
  bit calm;

  depth_to_point_backprojection #(.MAX_DIM(4096)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .depth_raw   (depth_raw),
    .empty       (empty),
    .pop         (pop),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_valid (point_valid),
    .pixel_index (pixel_index),
    .frame_end   (frame_end)
  );

  dpb_point_checker #(.MAX_DIM(4096)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .depth_raw      (depth_raw),
    .empty          (empty),
    .pop            (pop),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .point_valid    (point_valid),
    .pixel_index    (pixel_index),
    .frame_end      (frame_end),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .points_checked (points_checked),
    .valid_points   (valid_points),
    .frames_closed  (frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a long run of cycles with no handshake on any channel means a hang
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one register write; valid stays up so back-to-back writes need no gap
  task automatic write_reg(input logic [dpb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // load a full camera setting, only called while the block is idle
  task automatic program_camera(input logic [31:0] w, input logic [31:0] h,
                                input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] fx, input logic [31:0] fy,
                                input logic [31:0] ds);
    write_reg(dpb_pkg::REG_FRAME_WIDTH, w);
    write_reg(dpb_pkg::REG_FRAME_HEIGHT, h);
    write_reg(dpb_pkg::REG_PRINCIPAL_X, px);
    write_reg(dpb_pkg::REG_PRINCIPAL_Y, py);
    write_reg(dpb_pkg::REG_INV_FOCAL_X, fx);
    write_reg(dpb_pkg::REG_INV_FOCAL_Y, fy);
    write_reg(dpb_pkg::REG_INV_DEPTH_SCALE, ds);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // offer one depth word, sometimes after an idle burst
  task automatic send_word(input logic [dpb_pkg::DEPTH_W-1:0] d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push      <= 1'b1;
    depth_raw <= d;
    do @(posedge clk); while (full);
  endtask

  // lower push, then wait until every point word came back and the pipe is empty
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly valid depths, with a share of holes and extreme values
  function automatic logic [dpb_pkg::DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // random camera: small frames mostly so frame ends come often, extremes now and then
  task automatic random_camera();
    logic [31:0] w, h, px, py, fx, fy, ds;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = 8191;
      2:       w = 4096;
      default: w = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0:       h = 0;
      1:       h = 8191;
      2:       h = 4097;
      default: h = $urandom_range(1, 20);
    endcase
    case ($urandom_range(0, 7))
      0:       px = 0;
      1:       px = 32'h0000_FFFF;
      default: px = $urandom_range(0, 16 * 40);
    endcase
    case ($urandom_range(0, 7))
      0:       py = 0;
      1:       py = 32'h0000_FFFF;
      default: py = $urandom_range(0, 16 * 20);
    endcase
    case ($urandom_range(0, 7))
      0:       fx = 0;
      1:       fx = 32'h00FF_FFFF;
      2:       fx = $urandom_range(0, 32'h00FF_FFFF);
      default: fx = $urandom_range(16000, 70000);
    endcase
    case ($urandom_range(0, 7))
      0:       fy = 0;
      1:       fy = 32'h00FF_FFFF;
      2:       fy = $urandom_range(0, 32'h00FF_FFFF);
      default: fy = $urandom_range(16000, 70000);
    endcase
    case ($urandom_range(0, 7))
      0:       ds = 0;
      1:       ds = 32'hFFFF_FFFF;
      2:       ds = $urandom();
      default: ds = $urandom_range(100000, 2000000);
    endcase
    // junk above the register width must be dropped by the block
    if ($urandom_range(0, 3) == 0) w  = w  | ($urandom() << 13);
    if ($urandom_range(0, 3) == 0) h  = h  | ($urandom() << 13);
    if ($urandom_range(0, 3) == 0) px = px | ($urandom() << 16);
    if ($urandom_range(0, 3) == 0) fy = fy | ($urandom() << 24);
    program_camera(w, h, px, py, fx, fy, ds);
  endtask

  // point sink: random pop bursts, one long hold-off on request, none at the end
  initial begin
    pop = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // depth word source and register programming
  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = dpb_pkg::REG_FRAME_WIDTH;
    cfg_data  = '0;
    push      = 1'b0;
    depth_raw = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // 1x1 frame via zero sizes: every word closes a frame, z saturates on big depths,
    // and a principal row far below the image drives y into negative saturation
    program_camera(0, 0, 0, 32'h0000_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    send_word(16'd0);
    send_word(16'd1);
    send_word(16'hFFFF);
    send_word(16'h8000);
    send_word(16'h5555);
    send_word(16'hAAAA);
    settle();

    // oversized width acts as the maximum; columns two and up saturate x positive
    program_camera(8191, 2, 0, 0, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    repeat (4) send_word(16'hFFFF);
    settle();

    // shrink the frame mid-row: column counter is past the new bound and must wrap;
    // zero reciprocals give a valid point at the origin
    program_camera(2, 2, 16, 8, 0, 0, 0);
    send_word(16'd1);
    send_word(16'hFFFF);
    send_word(16'd0);
    send_word(16'd7);
    settle();

    // power-on camera setting with ordinary depths
    program_camera(640, 480, 5120, 3840, 32263, 32263, 858993);
    send_word(16'd1000);
    send_word(16'd5000);
    send_word(16'd0);
    send_word(16'd12345);
    send_word(16'hFFFF);
    settle();

    // random camera settings; the second one holds the sink back so the queue
    // fills and push stalls, the last two run without any idling
    for (int ph = 0; ph < 10; ph++) begin
      random_camera();
      if (ph == 1) hold_request = 1'b1;
      if (ph >= 8) calm = 1'b1;
      repeat ((ph == 1) ? 300 : 100) send_word(pick_depth());
      settle();
    end

    $display("checked %0d point words (%0d with depth, %0d frame ends) over %0d camera settings",
             points_checked, valid_points, frames_closed, settings_used);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dpb_pkg.sv
design/dpb_fifo.sv
design/dpb_front.sv
design/dpb_back.sv
design/depth_to_point_backprojection.sv
dv/dpb_point_checker.sv
dv/tb_depth_to_point_backprojection.sv
